/* rtl/icv_pkg.sv */
// Shared types and constants for the image window convolution block.
package icv_pkg;

  localparam int PIX_W   = 16;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = PIX_W + COEF_W;
  localparam int CIDX_W  = 8;
  localparam int POS_W   = 10;
  localparam int SIZE_W  = 11;
  localparam int RAD_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd1024;
  localparam logic [RAD_W-1:0]  RADIUS_RST = 3'd3;

  // per-cell controls for one window position
  typedef struct packed {
    logic shift;
    logic load;
    logic coef_we;
    logic prod_en;
    logic active;
  } cell_ctl_t;

endpackage

/* rtl/icv_ram.sv */
// Generic single-write, single-read RAM with registered read (read-first).
module icv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/icv_cell.sv */
// One window cell: pixel register, kernel coefficient and registered product.
module icv_cell (
  input  logic                         clk,
  input  icv_pkg::cell_ctl_t           ctl,
  input  logic [icv_pkg::PIX_W-1:0]    nbr_i,
  input  logic [icv_pkg::PIX_W-1:0]    load_i,
  input  logic [icv_pkg::COEF_W-1:0]   coef_i,
  output logic [icv_pkg::PIX_W-1:0]    win_o,
  output logic [icv_pkg::PROD_W-1:0]   prod_o
);

  logic [icv_pkg::PIX_W-1:0]  win_r;
  logic [icv_pkg::COEF_W-1:0] coef_r;
  logic [icv_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r <= nbr_i;
    end else if (ctl.load) begin
      win_r <= load_i;
    end
    if (ctl.coef_we) begin
      coef_r <= coef_i;
    end
    if (ctl.prod_en) begin
      prod_r <= ctl.active ? win_r * coef_r : '0;
    end
  end

  assign win_o  = win_r;
  assign prod_o = prod_r;

endmodule

/* rtl/image_window_convolution.sv */
// Top level: streaming 2D convolution over a row of window cells and line RAMs.
//
//  channel | ports                         | contents
//  --------+-------------------------------+------------------------------------------
//  input   | in_tvalid/in_tready/in_tdata  | opcode in tuser; coef_index, coef_value,
//          | in_tuser                      | pixel in tdata
//  output  | out_tvalid/out_tready/tdata   | value, out_row, out_col in tdata;
//          | out_tlast                     | frame_last in tlast
//  config  | cfg_wr_en/cfg_index/cfg_data  | image_width, image_height, kernel_radius
//
// One transaction per cycle in both directions while the output is not stalled; a result is
// offered after its pixel has passed the line RAM read, window update, cell multipliers
// and a two-stage sum (row sums, then total) with rounding into the output register.
// Reset is synchronous, active low, and clears counters, config and valid flags only.
// A full output register that is not taken stalls the whole pipeline and in_tready.
module image_window_convolution #(
  parameter int MAX_RADIUS = 6,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // coef_index[7:0], coef_value[23:8], pixel[39:24]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // value[15:0], out_row[25:16], out_col[35:26], zeros
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [icv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [icv_pkg::SIZE_W-1:0]    cfg_data
);

  localparam int KDIM  = 2 * MAX_RADIUS + 1;
  localparam int LINES = 2 * MAX_RADIUS;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int RDW   = $clog2(MAX_RADIUS + 1);
  localparam int SPW   = $clog2(LINES + 1);
  localparam int SLW   = $clog2(LINES);
  localparam int ROWS_W = icv_pkg::PROD_W + $clog2(KDIM);
  localparam int ACC_W  = icv_pkg::PROD_W + $clog2(KDIM * KDIM);

  // configuration
  logic [icv_pkg::SIZE_W-1:0] width_r, height_r;
  logic [icv_pkg::RAD_W-1:0]  radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= icv_pkg::WIDTH_RST;
      height_r <= icv_pkg::HEIGHT_RST;
      radius_r <= icv_pkg::RADIUS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        icv_pkg::REG_WIDTH:  width_r  <= cfg_data;
        icv_pkg::REG_HEIGHT: height_r <= cfg_data;
        icv_pkg::REG_RADIUS: radius_r <= cfg_data[icv_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0]  w;
  logic [RW-1:0]  h;
  logic [RDW-1:0] r;
  logic [SPW-1:0] span;

  always_comb begin
    if (width_r == '0) w = CW'(1);
    else if (32'(width_r) > MAX_WIDTH) w = CW'(MAX_WIDTH);
    else w = CW'(width_r);
    if (height_r == '0) h = RW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h = RW'(MAX_HEIGHT);
    else h = RW'(height_r);
    if (32'(radius_r) > MAX_RADIUS) r = RDW'(MAX_RADIUS);
    else r = RDW'(radius_r);
    span = SPW'({r, 1'b0});
  end

  // pipeline enable: everything moves unless a result waits
  logic en;
  logic out_tvalid_r;
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  logic acc_in, acc_pix;
  assign acc_in  = in_tvalid && en;
  assign acc_pix = acc_in && (in_tuser == icv_pkg::OP_PIXEL);

  // position counters; row_mod_r[i] tracks row % (2i+2) for every radius
  logic [CW-1:0]  col_r, col_nxt, c0;
  logic [RW-1:0]  row_r, row_nxt, rw0;
  logic [SLW-1:0] row_mod_r [MAX_RADIUS];
  logic [SLW-1:0] row_mod_nxt [MAX_RADIUS];
  logic [SLW-1:0] m0v [MAX_RADIUS];
  logic [SLW-1:0] m0;
  logic           emit0, last0;

  function automatic logic [SLW-1:0] mod_inc(input logic [SLW-1:0] m, input logic [SPW-1:0] s);
    logic [SPW:0] t;
    t = (SPW+1)'(m) + 1'b1;
    if (t >= (SPW+1)'(s)) mod_inc = '0;
    else mod_inc = SLW'(t);
  endfunction

  always_comb begin
    c0  = col_r;
    rw0 = row_r;
    m0v = row_mod_r;
    if (c0 >= w) begin
      c0  = '0;
      rw0 = rw0 + 1'b1;
      for (int i = 0; i < MAX_RADIUS; i++) m0v[i] = mod_inc(m0v[i], SPW'(2 * i + 2));
    end
    if (rw0 >= h) begin
      rw0 = '0;
      for (int i = 0; i < MAX_RADIUS; i++) m0v[i] = '0;
    end
    m0 = '0;
    for (int i = 0; i < MAX_RADIUS; i++) begin
      if (RDW'(i + 1) == r) m0 = m0v[i];
    end
    emit0 = (rw0 >= RW'(span)) && (c0 >= CW'(span));
    last0 = (rw0 + 1'b1 == h) && (c0 + 1'b1 == w);
    col_nxt     = c0 + 1'b1;
    row_nxt     = rw0;
    row_mod_nxt = m0v;
    if (col_nxt >= w) begin
      col_nxt = '0;
      row_nxt = rw0 + 1'b1;
      for (int i = 0; i < MAX_RADIUS; i++) row_mod_nxt[i] = mod_inc(m0v[i], SPW'(2 * i + 2));
      if (row_nxt >= h) begin
        row_nxt = '0;
        for (int i = 0; i < MAX_RADIUS; i++) row_mod_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < MAX_RADIUS; i++) row_mod_r[i] <= '0;
    end else if (acc_pix) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      row_mod_r <= row_mod_nxt;
    end
  end

  logic [icv_pkg::PIX_W-1:0] in_px;
  assign in_px = in_tdata[39:24];

  // line RAMs, one per buffered row slot
  logic [LINES-1:0]           ram_we;
  logic [icv_pkg::PIX_W-1:0]  ram_rd [LINES];

  for (genvar s = 0; s < LINES; s++) begin : g_line
    assign ram_we[s] = acc_pix && (span != '0) && (m0 == SLW'(s));
    icv_ram #(.WIDTH(icv_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (ram_we[s]),
      .waddr (c0[AW-1:0]),
      .wdata (in_px),
      .re    (acc_pix),
      .raddr (c0[AW-1:0]),
      .rdata (ram_rd[s])
    );
  end

  // stage 1: item registered, RAM data arrives
  logic                         s1_vld_r, s1_pix_r, s1_emit_r, s1_last_r;
  logic [icv_pkg::PIX_W-1:0]    s1_px_r;
  logic [SLW-1:0]               s1_m_r;
  logic [SPW-1:0]               s1_span_r;
  logic [icv_pkg::POS_W-1:0]    s1_row_r, s1_col_r;
  logic [icv_pkg::CIDX_W-1:0]   s1_cidx_r;
  logic [icv_pkg::COEF_W-1:0]   s1_cval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix_r  <= in_tuser == icv_pkg::OP_PIXEL;
      s1_emit_r <= emit0;
      s1_last_r <= last0;
      s1_px_r   <= in_px;
      s1_m_r    <= m0;
      s1_span_r <= span;
      s1_row_r  <= icv_pkg::POS_W'(rw0 - RW'(r));
      s1_col_r  <= icv_pkg::POS_W'(c0 - CW'(r));
      s1_cidx_r <= in_tdata[7:0];
      s1_cval_r <= in_tdata[23:8];
    end
  end

  logic upd, cwr;
  assign upd = en && s1_vld_r && s1_pix_r;
  assign cwr = en && s1_vld_r && !s1_pix_r;

  // row routing: window row kr takes slot (row + kr) % span
  logic [icv_pkg::PIX_W-1:0] row_ld [KDIM];

  for (genvar kr = 0; kr < KDIM; kr++) begin : g_route
    if (kr < LINES) begin : g_ln
      logic [SPW:0] sum;
      logic [SPW:0] slot;
      always_comb begin
        sum  = (SPW+1)'(s1_m_r) + (SPW+1)'(kr);
        slot = (sum >= (SPW+1)'(s1_span_r)) ? sum - (SPW+1)'(s1_span_r) : sum;
        if ((SPW+1)'(kr) == (SPW+1)'(s1_span_r)) row_ld[kr] = s1_px_r;
        else row_ld[kr] = ram_rd[slot[SLW-1:0]];
      end
    end else begin : g_px
      assign row_ld[kr] = s1_px_r;
    end
  end

  // stage W: window updated; flags of that pixel
  logic                      w_emit_r, w_last_r;
  logic [SPW-1:0]            w_span_r;
  logic [icv_pkg::POS_W-1:0] w_row_r, w_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_emit_r <= 1'b0;
    end else if (en) begin
      w_emit_r <= s1_vld_r && s1_pix_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_last_r <= s1_last_r;
      w_span_r <= s1_span_r;
      w_row_r  <= s1_row_r;
      w_col_r  <= s1_col_r;
    end
  end

  // cell array
  logic [icv_pkg::PIX_W-1:0]  win  [KDIM][KDIM];
  logic [icv_pkg::PROD_W-1:0] prod [KDIM][KDIM];

  for (genvar kr = 0; kr < KDIM; kr++) begin : g_row
    for (genvar kc = 0; kc < KDIM; kc++) begin : g_col
      icv_pkg::cell_ctl_t ctl;
      logic [icv_pkg::PIX_W-1:0] nbr;
      assign ctl.shift   = upd && ((SPW+1)'(kr) <= (SPW+1)'(s1_span_r))
                           && ((SPW+1)'(kc) < (SPW+1)'(s1_span_r));
      assign ctl.load    = upd && ((SPW+1)'(kr) <= (SPW+1)'(s1_span_r))
                           && ((SPW+1)'(kc) == (SPW+1)'(s1_span_r));
      assign ctl.coef_we = cwr && (32'(s1_cidx_r) == kr * KDIM + kc);
      assign ctl.prod_en = en;
      assign ctl.active  = ((SPW+1)'(kr) <= (SPW+1)'(w_span_r))
                           && ((SPW+1)'(kc) <= (SPW+1)'(w_span_r));
      if (kc < KDIM - 1) begin : g_n
        assign nbr = win[kr][kc+1];
      end else begin : g_e
        assign nbr = win[kr][kc];
      end
      icv_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .nbr_i  (nbr),
        .load_i (row_ld[kr]),
        .coef_i (s1_cval_r),
        .win_o  (win[kr][kc]),
        .prod_o (prod[kr][kc])
      );
    end
  end

  // stage P: products in cells; flags follow
  logic                      p_emit_r, p_last_r;
  logic [icv_pkg::POS_W-1:0] p_row_r, p_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_emit_r <= 1'b0;
    end else if (en) begin
      p_emit_r <= w_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_last_r <= w_last_r;
      p_row_r  <= w_row_r;
      p_col_r  <= w_col_r;
    end
  end

  // stage R: row sums
  logic [ROWS_W-1:0]         rsum_r [KDIM];
  logic                      r_emit_r, r_last_r;
  logic [icv_pkg::POS_W-1:0] r_row_r, r_col_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int kr = 0; kr < KDIM; kr++) begin
        logic [ROWS_W-1:0] s;
        s = '0;
        for (int kc = 0; kc < KDIM; kc++) begin
          s = s + ROWS_W'(prod[kr][kc]);
        end
        rsum_r[kr] <= s;
      end
      r_last_r <= p_last_r;
      r_row_r  <= p_row_r;
      r_col_r  <= p_col_r;
    end
  end

  // stage T: window total
  logic [ACC_W-1:0]          tot_r;
  logic                      t_emit_r, t_last_r;
  logic [icv_pkg::POS_W-1:0] t_row_r, t_col_r;

  always_ff @(posedge clk) begin
    if (en) begin
      logic [ACC_W-1:0] s;
      s = '0;
      for (int kr = 0; kr < KDIM; kr++) begin
        s = s + ACC_W'(rsum_r[kr]);
      end
      tot_r    <= s;
      t_last_r <= r_last_r;
      t_row_r  <= r_row_r;
      t_col_r  <= r_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_emit_r <= 1'b0;
      t_emit_r <= 1'b0;
    end else if (en) begin
      r_emit_r <= p_emit_r;
      t_emit_r <= r_emit_r;
    end
  end

  // round half up, saturate, output register
  logic [ACC_W:0]            rnd;
  logic [icv_pkg::PIX_W-1:0] sat;
  assign rnd = (ACC_W+1)'(tot_r) + (ACC_W+1)'(32768);
  assign sat = (rnd[ACC_W:16] > (ACC_W-15)'(16'hFFFF)) ? '1 : rnd[31:16];

  logic [icv_pkg::PIX_W-1:0] out_val_r;
  logic [icv_pkg::POS_W-1:0] out_row_r, out_col_r;
  logic                      out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= t_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r  <= sat;
      out_row_r  <= t_row_r;
      out_col_r  <= t_col_r;
      out_last_r <= t_last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, out_col_r, out_row_r, out_val_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_one_line_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ram_we))
    else $error("more than one line RAM written");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < MAX_WIDTH)
    else $error("column counter out of range");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) < MAX_HEIGHT)
    else $error("row counter out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_tvalid_r) && $stable(out_val_r) && $stable(t_emit_r))
    else $error("pipeline moved during stall");
`endif

endmodule

/* bench/tb.sv */
// Self-checking testbench for the streaming window convolution block.
`timescale 1ns / 1ps

module tb;

  localparam int KDIM = 13;
  localparam int KCELLS = KDIM * KDIM;
  localparam int LWIDTH = 1024;

  typedef struct {
    logic                       op;
    logic [icv_pkg::CIDX_W-1:0] idx;
    logic [icv_pkg::COEF_W-1:0] coef;
    logic [icv_pkg::PIX_W-1:0]  pix;
  } stim_item_t;

  typedef struct {
    logic [15:0]               value;
    logic [icv_pkg::POS_W-1:0] row;
    logic [icv_pkg::POS_W-1:0] col;
    logic                      last;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [icv_pkg::CFG_IDX_W-1:0] cfg_index = icv_pkg::REG_WIDTH;
  logic [icv_pkg::SIZE_W-1:0] cfg_data = '0;

  image_window_convolution u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [icv_pkg::SIZE_W-1:0] cur_width = icv_pkg::WIDTH_RST;
  logic [icv_pkg::SIZE_W-1:0] cur_height = icv_pkg::HEIGHT_RST;
  logic [icv_pkg::RAD_W-1:0]  cur_radius = icv_pkg::RADIUS_RST;
  logic [15:0] kern_coefs [KCELLS];
  logic [15:0] line_rows [12*LWIDTH];
  logic [15:0] win_cells [KCELLS];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  stim_item_t   pending_items[$];
  filt_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int pixels_sent = 0;
  bit long_hold_done = 0;
  bit hold_req = 0;

  task automatic convolve_item(input stim_item_t it);
    int unsigned w, h, r, span, slot;
    logic [63:0] acc;
    filt_result_t res;
    if (it.op == icv_pkg::OP_COEF) begin
      if (it.idx < KCELLS) kern_coefs[it.idx] = it.coef;
      return;
    end
    w = (cur_width == 0) ? 1 : (cur_width > 1024 ? 1024 : cur_width);
    h = (cur_height == 0) ? 1 : (cur_height > 1024 ? 1024 : cur_height);
    r = (cur_radius > 6) ? 6 : cur_radius;
    span = 2 * r;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    for (int kr = 0; kr <= span; kr++)
      for (int kc = 0; kc < span; kc++)
        win_cells[kr*KDIM+kc] = win_cells[kr*KDIM+kc+1];
    if (span > 0) begin
      for (int kr = 0; kr < span; kr++) begin
        slot = (row_pos + kr) % span;
        win_cells[kr*KDIM+span] = line_rows[slot*LWIDTH+col_pos];
      end
      line_rows[(row_pos % span)*LWIDTH+col_pos] = it.pix;
    end
    win_cells[span*KDIM+span] = it.pix;
    if (row_pos >= span && col_pos >= span) begin
      acc = '0;
      for (int kr = 0; kr <= span; kr++)
        for (int kc = 0; kc <= span; kc++)
          acc += 64'(win_cells[kr*KDIM+kc]) * 64'(kern_coefs[kr*KDIM+kc]);
      acc = (acc + 64'd32768) >> 16;
      res.value = (acc > 64'd65535) ? 16'hFFFF : acc[15:0];
      res.row = icv_pkg::POS_W'(row_pos - r);
      res.col = icv_pkg::POS_W'(col_pos - r);
      res.last = (row_pos + 1 == h) && (col_pos + 1 == w);
      expected_results.push_back(res);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // sender
  int  send_gap = 0;
  bit  send_quiet = 0;
  always @(posedge clk) begin
    stim_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        convolve_item('{in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[39:24]});
        if ($urandom_range(0, 19) == 0) send_quiet = !send_quiet;
        send_gap = draw_gap(send_quiet);
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered transaction
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.op;
        in_tdata <= {nxt.pix, nxt.coef, nxt.idx};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver and checker
  int  recv_gap = 0;
  bit  recv_quiet = 0;
  always @(posedge clk) begin
    filt_result_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result tdata=%h", out_tdata);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata[15:0] !== exp_r.value) begin
            $error("value exp %0d got %0d", exp_r.value, out_tdata[15:0]);
            errors++;
          end
          if (out_tdata[25:16] !== exp_r.row) begin
            $error("out_row exp %0d got %0d", exp_r.row, out_tdata[25:16]);
            errors++;
          end
          if (out_tdata[35:26] !== exp_r.col) begin
            $error("out_col exp %0d got %0d", exp_r.col, out_tdata[35:26]);
            errors++;
          end
          if (out_tlast !== exp_r.last) begin
            $error("frame_last exp %0d got %0d", exp_r.last, out_tlast);
            errors++;
          end
        end
        if ($urandom_range(0, 19) == 0) recv_quiet = !recv_quiet;
        recv_gap = draw_gap(recv_quiet);
      end
      // one long hold-off so the pipeline backs up into the input
      if (hold_req && !long_hold_done) begin
        long_hold_done = 1;
        recv_gap = 300;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int h, input int r);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= icv_pkg::REG_WIDTH;
    cfg_data <= icv_pkg::SIZE_W'(w);
    @(posedge clk);
    cfg_index <= icv_pkg::REG_HEIGHT;
    cfg_data <= icv_pkg::SIZE_W'(h);
    @(posedge clk);
    cfg_index <= icv_pkg::REG_RADIUS;
    cfg_data <= icv_pkg::SIZE_W'(r);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_width = icv_pkg::SIZE_W'(w);
    cur_height = icv_pkg::SIZE_W'(h);
    cur_radius = icv_pkg::RAD_W'(r);
  endtask

  function automatic void queue_coef(input int idx, input int val);
    pending_items.push_back('{icv_pkg::OP_COEF, icv_pkg::CIDX_W'(idx),
                              icv_pkg::COEF_W'(val), icv_pkg::PIX_W'($urandom)});
    // pixel bits are don't-care here
  endfunction

  function automatic void queue_pixel(input int val);
    pending_items.push_back('{icv_pkg::OP_PIXEL, icv_pkg::CIDX_W'($urandom),
                              icv_pkg::COEF_W'($urandom), icv_pkg::PIX_W'(val)});
    pixels_sent++;
  endfunction

  // whole frames only, so counters are back at the origin before any register write
  function automatic void queue_frame(input int w, input int h, input int coef_pct);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < coef_pct) queue_coef($urandom_range(0, 255), $urandom);
      queue_pixel($urandom);
    end
  endfunction

  initial begin
    int w, h, r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // kernel at full scale, plus ignored indices
    for (int i = 0; i < KCELLS; i++) queue_coef(i, 16'hFFFF);
    queue_coef(169, 16'h0000);
    queue_coef(255, 16'h1234);

    // zero sizes act as one, radius zero: every pixel emits with last set
    set_geometry(0, 0, 0);
    queue_pixel(16'h0000);
    queue_pixel(16'hFFFF);
    queue_pixel(16'h0001);

    // 3x3 full-scale window saturates, then an all-zero frame
    set_geometry(3, 3, 1);
    for (int i = 0; i < 9; i++) queue_pixel(16'hFFFF);
    for (int i = 0; i < 9; i++) queue_pixel(16'h0000);

    // oversized registers saturate; window taller than image gives nothing
    set_geometry(2047, 1, 7);
    queue_frame(1024, 1, 0);

    // largest kernel on the smallest image that fits it
    set_geometry(13, 13, 6);
    for (int i = 0; i < KCELLS; i++) queue_coef(i, $urandom_range(0, 1200));
    queue_frame(13, 13, 0);

    // every pixel emits while the receiver holds off, so the input stalls
    set_geometry(16, 12, 0);
    hold_req = 1;
    queue_frame(16, 12, 0);

    // random geometries, whole frames, occasional coefficient rewrites
    while (pixels_sent < 1450) begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 12);
      r = $urandom_range(0, 7);
      set_geometry(w, h, r);
      for (int f = $urandom_range(1, 3); f > 0; f--) queue_frame(w, h, 8);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
rtl/icv_pkg.sv
rtl/icv_ram.sv
rtl/icv_cell.sv
rtl/image_window_convolution.sv
bench/tb.sv
